// ----- sv/lat_pkg.sv -----
package lat_pkg;

	// input beat: two log-domain operands, signed Q16.16
	typedef struct packed {
		logic signed [31:0] first_log;
		logic signed [31:0] second_log;
	} lat_req_t;

	// output beat: saturated log-sum and clip flag
	typedef struct packed {
		logic signed [31:0] log_total;
		logic               saturated;
	} lat_rsp_t;

	localparam logic [63:0] LN2_Q32 = 64'd2977044472;
	localparam logic [63:0] ONE_Q32 = 64'd4294967296;

	// restoring shift-subtract division, unsigned 64-bit quotient
	function automatic logic [63:0] udiv64(input logic [63:0] dividend,
			input logic [63:0] divisor);
		logic [64:0] part;
		logic [63:0] quo;
		part = '0;
		quo  = '0;
		for (int b = 63; b >= 0; b--) begin
			part = {part[63:0], dividend[b]};
			if (part >= {1'b0, divisor}) begin
				part   = part - {1'b0, divisor};
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// log(1+exp(-x)) for x in Q32, result in Q0.16, rounded and clamped
	// used only to fill the correction table at time zero
	function automatic logic [15:0] softplus_neg_q16(input logic [63:0] x);
		logic [63:0] k;
		logic [63:0] r;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] y;
		logic [63:0] num;
		logic [63:0] den;
		logic [63:0] q;
		logic [63:0] rem;
		logic [63:0] t;
		logic [63:0] t2;
		logic [63:0] p;
		logic [63:0] s;
		logic [63:0] i;
		k = udiv64(x, LN2_Q32);
		r = x - k * LN2_Q32;
		term = ONE_Q32;
		sum = ONE_Q32;
		// exp(r) by taylor series
		for (i = 64'd1; i <= 64'd24; i = i + 64'd1) begin
			term = udiv64((term * r) >> 32, i);
			sum = sum + term;
		end
		y = udiv64(64'hFFFF_FFFF_FFFF_FFFF, sum);
		y = (k >= 64'd64) ? 64'd0 : (y >> k);
		// y/(2+y), rounded
		num = y << 31;
		den = (64'd2 * ONE_Q32) + y;
		q = udiv64(num, den);
		rem = num - q * den;
		t = 64'd2 * q + (((64'd2 * rem) >= den) ? 64'd1 : 64'd0);
		t2 = (t * t) >> 32;
		s = t;
		p = t;
		// 2*atanh(t) series
		for (i = 64'd3; i <= 64'd41; i = i + 64'd2) begin
			p = (p * t2) >> 32;
			s = s + udiv64(p, i);
		end
		s = 64'd2 * s;
		s = (s + 64'd32768) >> 16;
		return (s > 64'h0000_0000_0000_FFFF) ? 16'hFFFF : s[15:0];
	endfunction

endpackage

// ----- sv/log_add_table_interp_unit.sv -----
// channel | valid     | ready     | payload | beat contents
// request | req_valid | req_ready | req     | first_log, second_log (Q16.16)
// result  | rsp_valid | rsp_ready | rsp     | log_total (Q16.16), saturated
//
// one beat per cycle sustained while the result side does not stall
// stages: compare/subtract, table read (two ports, n and n+1), multiply,
// add/saturate into the output register
// reset clears the stage valid bits only; the table is a constant rom
// a stall on the result side holds every stage, so req_ready follows rsp_ready
// whenever the output register is full
module log_add_table_interp_unit #(
	parameter int FRAC_BITS = 16,
	parameter int STEP_BITS = 10,
	parameter int CUTOFF    = 10,
	parameter int ROM_DEPTH = 10241
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  lat_pkg::lat_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output lat_pkg::lat_rsp_t rsp
);
	import lat_pkg::*;

	localparam int SH  = FRAC_BITS - STEP_BITS;
	localparam int PSH = (SH > 0) ? SH : 0;
	localparam int NSH = (SH < 0) ? -SH : 0;
	localparam int FW  = (SH > 0) ? SH : 1;
	localparam int CS  = FRAC_BITS - 16;
	localparam int CPS = (CS > 0) ? CS : 0;
	localparam int CNS = (CS < 0) ? -CS : 0;
	localparam int CW  = 16 + CPS;
	localparam int AW  = $clog2(ROM_DEPTH);
	localparam logic [63:0]   LIMIT  = 64'(CUTOFF) << FRAC_BITS;
	localparam logic [63:0]   LAST64 = 64'(ROM_DEPTH - 1);
	localparam logic [AW-1:0] LAST   = AW'(ROM_DEPTH - 1);

	// correction table, log(1+exp(-n/2^STEP_BITS)) in q0.16
	logic [15:0] corr_rom [ROM_DEPTH];

	initial begin
		for (int n = 0; n < ROM_DEPTH; n++) begin
			corr_rom[n] = softplus_neg_q16(64'(n) << (32 - STEP_BITS));
		end
	end

	logic en;

	logic               v1_s1, v2_s2, v3_s3, v4_s4;
	logic signed [31:0] hi_s1, hi_s2, hi_s3;
	logic [31:0]        d_s1;
	logic [15:0]        f0_s2, f1_s2, f0_s3;
	logic [FW-1:0]      frac_s2;
	logic               near_s2, near_s3, down_s3;
	logic [16+FW-1:0]   prod_s3;
	lat_rsp_t           rsp_s4;

	// whole pipe advances unless the output register is held
	assign en        = !v4_s4 || rsp_ready;
	assign req_ready = en;
	assign rsp_valid = v4_s4;
	assign rsp       = rsp_s4;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
		end else if (en) begin
			v1_s1 <= req_valid;
			v2_s2 <= v1_s1;
			v3_s3 <= v2_s2;
			v4_s4 <= v3_s3;
		end
	end

	// stage 1: max and absolute difference
	logic        a_less;
	logic [32:0] diff_wide;
	always_comb begin
		a_less    = req.first_log < req.second_log;
		diff_wide = a_less ? (33'(req.second_log) - 33'(req.first_log))
		                   : (33'(req.first_log) - 33'(req.second_log));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hi_s1 <= a_less ? req.second_log : req.first_log;
			d_s1  <= diff_wide[31:0];
		end
	end

	// stage 2: table index, clamp, rom read
	logic [63:0]   n_full;
	logic [AW-1:0] idx0, idx1;
	logic          near;
	logic [FW-1:0] frac;
	always_comb begin
		near   = {32'd0, d_s1} < LIMIT;
		n_full = (64'(d_s1) >> PSH) << NSH;
		idx0   = (n_full > LAST64) ? LAST : n_full[AW-1:0];
		idx1   = (idx0 == LAST) ? LAST : idx0 + AW'(1);
		frac   = (SH > 0) ? d_s1[FW-1:0] : '0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			f0_s2   <= corr_rom[idx0];
			f1_s2   <= corr_rom[idx1];
			frac_s2 <= frac;
			near_s2 <= near;
			hi_s2   <= hi_s1;
		end
	end

	// stage 3: slope times fraction
	logic        down;
	logic [15:0] delta;
	always_comb begin
		down  = f1_s2 <= f0_s2;
		delta = down ? (f0_s2 - f1_s2) : (f1_s2 - f0_s2);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s3 <= (16 + FW)'(delta) * (16 + FW)'(frac_s2);
			down_s3 <= down;
			f0_s3   <= f0_s2;
			near_s3 <= near_s2;
			hi_s3   <= hi_s2;
		end
	end

	// stage 4: interpolate, align, add and clip at the positive maximum
	logic [16+FW-1:0]   step_wide;
	logic [15:0]        c16;
	logic [CW-1:0]      corr;
	logic signed [33:0] total;
	logic               clip;
	always_comb begin
		step_wide = prod_s3 >> PSH;
		c16       = down_s3 ? (f0_s3 - step_wide[15:0]) : (f0_s3 + step_wide[15:0]);
		corr      = near_s3 ? ((CW'(c16) << CPS) >> CNS) : '0;
		total     = 34'(hi_s3) + $signed({1'b0, 33'(corr)});
		clip      = !total[33] && (total[32:31] != 2'b00);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rsp_s4.log_total <= clip ? 32'sh7FFF_FFFF : total[31:0];
			rsp_s4.saturated <= clip;
		end
	end

endmodule
